// ===== rtl/scancode_to_ascii_fifo_top_defines.svh =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top_defines
// assertion macros for the scancode translator rtl
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH
`define SCANCODE_TO_ASCII_FIFO_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SC2A_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("sc2a same-cycle check failed");

// next-cycle implication, checked outside reset
`define SC2A_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("sc2a next-cycle check failed");

`endif

// ===== rtl/sc2a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_pkg
// types, codes and the set 1 key table of the scancode translator
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int OPCODE_W = 2;
  localparam int CODE_W   = 8;

  localparam logic [OPCODE_W-1:0] OP_SCAN  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ACT   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [CODE_W-1:0] SC_LSHIFT    = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT    = 8'h36;
  localparam logic [CODE_W-1:0] SC_LSHIFT_UP = 8'hAA;
  localparam logic [CODE_W-1:0] SC_RSHIFT_UP = 8'hB6;
  localparam logic [CODE_W-1:0] SC_CTRL      = 8'h1D;
  localparam logic [CODE_W-1:0] SC_CTRL_UP   = 8'h9D;
  localparam logic [CODE_W-1:0] SC_CAPS      = 8'h3A;

  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CH_LOWER_C = 8'h63;
  localparam logic [CODE_W-1:0] CH_LOWER_D = 8'h64;
  localparam logic [CODE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [CODE_W-1:0] CH_BAR     = 8'h7C;
  localparam logic [CODE_W-1:0] CH_SEVEN   = 8'h37;
  localparam logic [CODE_W-1:0] CH_AMP     = 8'h26;
  localparam logic [CODE_W-1:0] CH_EOF     = 8'hFF;
  localparam logic [CODE_W-1:0] CASE_MASK  = 8'hDF;

  typedef struct packed {
    logic [CODE_W-1:0] char_out;
    logic              char_valid;
    logic              activity;
    logic              overflow;
    logic              kill_request;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic exec;      // apply the accepted command
    logic rd_issue;  // ring read started for a pop
    logic pop_done;  // ring read data is back
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;   // pending beat is a pop on a non-empty ring
    logic res_full;  // result queue has no free slot
  } sts_t;

  function automatic logic [CODE_W-1:0] keymap(input logic [6:0] code);
    logic [CODE_W-1:0] ch;
    ch = 8'h00;
    case (code)
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h3D;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h5B;
      7'd27: ch = 8'h5D;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h3B;
      7'd40: ch = 8'h27;
      7'd41: ch = 8'h60;
      7'd43: ch = 8'h5C;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2F;
      7'd57: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/sc2a_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface sc2a_in_if;
  logic                          valid;
  logic                          ready;
  logic [sc2a_pkg::OPCODE_W-1:0] opcode;
  logic [sc2a_pkg::CODE_W-1:0]   scan_code;

  modport source (output valid, output opcode, output scan_code, input ready);
  modport sink   (input valid, input opcode, input scan_code, output ready);
endinterface

interface sc2a_out_if;
  logic                        valid;
  logic                        ready;
  logic [sc2a_pkg::CODE_W-1:0] char_out;
  logic                        char_valid;
  logic                        activity;
  logic                        overflow;
  logic                        kill_request;

  modport source (output valid, output char_out, output char_valid, output activity,
                  output overflow, output kill_request, input ready);
  modport sink   (input valid, input char_out, input char_valid, input activity,
                  input overflow, input kill_request, output ready);
endinterface

// ===== rtl/sc2a_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_ctrl
// command sequencer: accepts beats, waits in the pop state on ring reads
// ----------------------------------------------------------------------------
module sc2a_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sc2a_pkg::sts_t     sts,
  output sc2a_pkg::cmd_t     cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_POP  = 1'b1;

  logic [0:0] state_r;
  logic [0:0] state_nxt;

  always_comb begin
    in_ready     = (state_r == ST_IDLE) && !sts.res_full;
    cmd.exec     = in_valid && in_ready;
    cmd.rd_issue = cmd.exec && sts.pop_hit;
    cmd.pop_done = (state_r == ST_POP);
    state_nxt    = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.rd_issue) state_nxt = ST_POP;
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sc2a_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_datapath
// modifiers, key translation, character ring and result queue
// ----------------------------------------------------------------------------
module sc2a_datapath #(
  parameter int DEPTH = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sc2a_pkg::cmd_t                cmd,
  output sc2a_pkg::sts_t                sts,
  input  logic [sc2a_pkg::OPCODE_W-1:0] opcode,
  input  logic [sc2a_pkg::CODE_W-1:0]   scan_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sc2a_pkg::res_t                out_res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [sc2a_pkg::CODE_W-1:0] ring_mem [DEPTH];
  logic [sc2a_pkg::CODE_W-1:0] rd_data_r;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_inc, rd_ptr_inc;
  logic          shift_r, shift_nxt, caps_r, caps_nxt, ctrl_r, ctrl_nxt;
  logic          act_r, act_nxt;

  logic                        ring_empty, ring_full;
  logic                        push_req, kill_hit, wr_en;
  logic [sc2a_pkg::CODE_W-1:0] ch_map, ch_case, ch_push;

  sc2a_pkg::res_t res_new;
  logic           enq, deq;
  logic [1:0]     cnt_r, cnt_nxt;
  sc2a_pkg::res_t q0_r, q0_nxt, q1_r, q1_nxt;

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign ring_empty = (wr_ptr_r == rd_ptr_r);
  assign ring_full  = (wr_ptr_inc == rd_ptr_r);

  // key translation
  always_comb begin
    ch_map  = sc2a_pkg::keymap(scan_code[6:0]);
    ch_case = ch_map;
    if ((ch_map inside {[sc2a_pkg::CH_LOWER_A:sc2a_pkg::CH_LOWER_Z]}) && (shift_r || caps_r))
      ch_case = ch_map & sc2a_pkg::CASE_MASK;
    if (ch_case == sc2a_pkg::CH_BSLASH && shift_r) ch_case = sc2a_pkg::CH_BAR;
    if (ch_case == sc2a_pkg::CH_SEVEN && shift_r)  ch_case = sc2a_pkg::CH_AMP;
    kill_hit = ctrl_r && (ch_case == sc2a_pkg::CH_LOWER_C);
    ch_push  = (ctrl_r && ch_case == sc2a_pkg::CH_LOWER_D) ? sc2a_pkg::CH_EOF : ch_case;
  end

  // command execution
  always_comb begin
    shift_nxt  = shift_r;
    caps_nxt   = caps_r;
    ctrl_nxt   = ctrl_r;
    act_nxt    = act_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    push_req   = 1'b0;
    res_new    = '0;
    wr_en      = 1'b0;
    if (cmd.exec) begin
      case (opcode)
        sc2a_pkg::OP_SCAN: begin
          act_nxt = 1'b1;
          if (scan_code inside {sc2a_pkg::SC_LSHIFT, sc2a_pkg::SC_RSHIFT}) begin
            shift_nxt = 1'b1;
          end else if (scan_code inside {sc2a_pkg::SC_LSHIFT_UP, sc2a_pkg::SC_RSHIFT_UP}) begin
            shift_nxt = 1'b0;
          end else if (scan_code == sc2a_pkg::SC_CTRL) begin
            ctrl_nxt = 1'b1;
          end else if (scan_code == sc2a_pkg::SC_CTRL_UP) begin
            ctrl_nxt = 1'b0;
          end else if (scan_code == sc2a_pkg::SC_CAPS) begin
            caps_nxt = ~caps_r;
          end else if (!scan_code[7]) begin
            if (kill_hit) begin
              res_new.kill_request = 1'b1;
            end else begin
              push_req = 1'b1;
            end
          end
          if (push_req) begin
            if (ring_full) begin
              res_new.overflow = 1'b1;
            end else begin
              wr_en      = 1'b1;
              wr_ptr_nxt = wr_ptr_inc;
            end
          end
        end
        sc2a_pkg::OP_POP: begin
          if (!ring_empty) rd_ptr_nxt = rd_ptr_inc;
        end
        sc2a_pkg::OP_ACT: begin
          res_new.activity = act_r;
          act_nxt          = 1'b0;
        end
        sc2a_pkg::OP_CLEAR: begin
          wr_ptr_nxt = '0;
          rd_ptr_nxt = '0;
        end
        default: begin
          res_new = '0;
        end
      endcase
    end
    if (cmd.pop_done) begin
      res_new            = '0;
      res_new.char_out   = rd_data_r;
      res_new.char_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_ptr_r] <= ch_push;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_data_r <= ring_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      shift_r  <= 1'b0;
      caps_r   <= 1'b0;
      ctrl_r   <= 1'b0;
      act_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      shift_r  <= shift_nxt;
      caps_r   <= caps_nxt;
      ctrl_r   <= ctrl_nxt;
      act_r    <= act_nxt;
    end
  end

  // two-entry result queue, head drives the output
  assign enq       = (cmd.exec && !cmd.rd_issue) || cmd.pop_done;
  assign out_valid = (cnt_r != 2'd0);
  assign deq       = out_valid && out_ready;
  assign out_res   = q0_r;

  always_comb begin
    cnt_nxt = 2'(cnt_r + {1'b0, enq} - {1'b0, deq});
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (deq) begin
      q0_nxt = (cnt_r == 2'd2) ? q1_r : res_new;
    end else if (cnt_r == 2'd0) begin
      q0_nxt = res_new;
    end
    if (enq && (((cnt_r == 2'd1) && !deq) || ((cnt_r == 2'd2) && deq))) q1_nxt = res_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign sts.pop_hit  = (opcode == sc2a_pkg::OP_POP) && !ring_empty;
  assign sts.res_full = (cnt_r == 2'd2);

endmodule

// ===== rtl/scancode_to_ascii_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top
// set 1 scancode translator with a character ring and command interface
// ----------------------------------------------------------------------------
//
// channel   dir  handshake     payload
// in_ch     in   valid/ready   opcode[1:0], scan_code[7:0]
// out_ch    out  valid/ready   char_out[7:0], char_valid, activity, overflow,
//                              kill_request
//
// every command beat yields exactly one result beat
// scancode, activity read, clear and empty pop: one beat per cycle while the result queue has room
// pop of a stored character: the sequencer waits in its pop state for the registered ring read port
// reset zeroes pointers, modifiers and activity; ring contents are not cleared
// a two-entry result queue decouples the sides; besides the pop read cycle,
// in_ch stalls only while that queue is full
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_top_defines.svh"

module scancode_to_ascii_fifo_top #(
  parameter int DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  sc2a_in_if.sink           in_ch,
  sc2a_out_if.source        out_ch
);

  // command and status between sequencer and datapath
  sc2a_pkg::cmd_t cmd;
  sc2a_pkg::sts_t sts;
  sc2a_pkg::res_t res;
  logic           in_ready;
  logic           out_valid;

  sc2a_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sc2a_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .opcode    (in_ch.opcode),
    .scan_code (in_ch.scan_code),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // drive the channels
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.char_out     = res.char_out;
  assign out_ch.char_valid   = res.char_valid;
  assign out_ch.activity     = res.activity;
  assign out_ch.overflow     = res.overflow;
  assign out_ch.kill_request = res.kill_request;

  // ring read always returns on the following cycle
  `SC2A_ASSERT_NEXT(a_pop_returns, clk, rst_n, cmd.rd_issue, cmd.pop_done)

  // no new command while a ring read is in flight
  `SC2A_ASSERT_NOW(a_no_accept_in_pop, clk, rst_n, cmd.pop_done, !in_ready)

  // a popped character carries no other flag
  `SC2A_ASSERT_NOW(a_char_alone, clk, rst_n, out_valid && res.char_valid,
                   !res.activity && !res.overflow && !res.kill_request)

endmodule

// ===== test/tb_scancode_to_ascii_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo_top
// self-checking bench for the set 1 scancode translator and its character ring
// ----------------------------------------------------------------------------
// a short hand-written table opens the run: reset values, empty pops, ignored
// break codes, shift, caps lock and ctrl handling. random traffic follows in
// four pacing phases that mix typing bursts, ring overfills, pop drains and
// noise. every accepted command is run through a behavioral shadow of the
// translator, and each reply beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo_top;

  localparam int RING_DEPTH    = 128;
  localparam int RING_PW       = $clog2(RING_DEPTH);
  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int PHASE_BEATS   = 175;
  localparam int SETTLE_CYCLES = 8;

  // canned replies that can be read straight off the spec
  localparam sc2a_pkg::res_t QUIET_REPLY    = '0;
  localparam sc2a_pkg::res_t ACTIVITY_REPLY = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam sc2a_pkg::res_t NUL_POP_REPLY  = '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0};
  localparam sc2a_pkg::res_t KILL_REPLY     = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1};

  // one row of the directed table; typed rows carry their own reply
  typedef struct packed {
    logic [sc2a_pkg::OPCODE_W-1:0] op;
    logic [sc2a_pkg::CODE_W-1:0]   code;
    logic                          typed;
    sc2a_pkg::res_t                want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;

  sc2a_in_if  in_ch ();
  sc2a_out_if out_ch ();

  scancode_to_ascii_fifo_top #(
    .DEPTH(RING_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // set 1 make codes 0x00..0x39 to ascii; everything above maps to zero
  logic [7:0] set1_ascii [0:57] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,   // esc, 1..6
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,   // 7..0 - = bs tab
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,   // q w e r t y u i
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,   // o p [ ] enter ctrl a s
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,   // d f g h j k l ;
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,   // ' ` lshift \ z x c v
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,   // b n m , . / rshift *
    8'h00, 8'h20                                              // alt space
  };

  // shadow of the translator state
  logic [7:0]  shadow_ring [0:RING_DEPTH-1];
  int unsigned shadow_wr;
  int unsigned shadow_rd;
  logic        shift_on;
  logic        caps_lock;
  logic        ctrl_on;
  logic        key_seen;

  sc2a_pkg::res_t replies_due [$];
  int             mismatch_count;

  // pacing knobs, in percent per cycle
  int src_idle_pct;
  int snk_stall_pct;

  // side info travelling with the beat on in_ch
  logic           beat_typed;
  sc2a_pkg::res_t beat_want;

  // ---------------------------------------------------------------------------
  // behavioral translator: applies one command, returns its reply
  // ---------------------------------------------------------------------------
  function automatic sc2a_pkg::res_t next_reply(input logic [sc2a_pkg::OPCODE_W-1:0] op,
                                                input logic [sc2a_pkg::CODE_W-1:0] code);
    sc2a_pkg::res_t r;
    logic [7:0]     ch;
    int unsigned    nxt;
    r = '0;
    case (op)
      sc2a_pkg::OP_SCAN: begin
        key_seen = 1'b1;
        if (code == sc2a_pkg::SC_LSHIFT || code == sc2a_pkg::SC_RSHIFT) begin
          shift_on = 1'b1;
        end else if (code == sc2a_pkg::SC_LSHIFT_UP || code == sc2a_pkg::SC_RSHIFT_UP) begin
          shift_on = 1'b0;
        end else if (code == sc2a_pkg::SC_CTRL) begin
          ctrl_on = 1'b1;
        end else if (code == sc2a_pkg::SC_CTRL_UP) begin
          ctrl_on = 1'b0;
        end else if (code == sc2a_pkg::SC_CAPS) begin
          caps_lock = !caps_lock;
        end else if (!code[7]) begin
          ch = (code < $size(set1_ascii)) ? set1_ascii[code[5:0]] : 8'h00;
          if (ch >= sc2a_pkg::CH_LOWER_A && ch <= sc2a_pkg::CH_LOWER_Z &&
              (shift_on || caps_lock)) begin
            ch = ch & sc2a_pkg::CASE_MASK;
          end
          if (ch == sc2a_pkg::CH_BSLASH && shift_on) ch = sc2a_pkg::CH_BAR;
          if (ch == sc2a_pkg::CH_SEVEN && shift_on) ch = sc2a_pkg::CH_AMP;
          // ctrl looks at the character after case folding
          if (ctrl_on && ch == sc2a_pkg::CH_LOWER_C) begin
            r.kill_request = 1'b1;
          end else begin
            if (ctrl_on && ch == sc2a_pkg::CH_LOWER_D) ch = sc2a_pkg::CH_EOF;
            nxt = (shadow_wr + 1) % RING_DEPTH;
            if (nxt == shadow_rd) begin
              r.overflow = 1'b1;
            end else begin
              shadow_ring[RING_PW'(shadow_wr)] = ch;
              shadow_wr = nxt;
            end
          end
        end
      end
      sc2a_pkg::OP_POP: begin
        if (shadow_wr != shadow_rd) begin
          r.char_out   = shadow_ring[RING_PW'(shadow_rd)];
          r.char_valid = 1'b1;
          shadow_rd    = (shadow_rd + 1) % RING_DEPTH;
        end
      end
      sc2a_pkg::OP_ACT: begin
        r.activity = key_seen;
        key_seen   = 1'b0;
      end
      sc2a_pkg::OP_CLEAR: begin
        // clear keeps modifiers and the activity flag
        shadow_wr = 0;
        shadow_rd = 0;
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // both handshakes are observed in one process so that a beat accepted and
  // a reply leaving at the same edge are always handled in the same order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sc2a_pkg::res_t predicted;
    sc2a_pkg::res_t seen;
    sc2a_pkg::res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = next_reply(in_ch.opcode, in_ch.scan_code);
        replies_due.push_back(beat_typed ? beat_want : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.char_out, out_ch.char_valid, out_ch.activity,
                out_ch.overflow, out_ch.kill_request};
        if (replies_due.size() == 0) begin
          report_mismatch("reply beat with nothing due", int'(seen), 0);
        end else begin
          want = replies_due.pop_front();
          if (seen.char_out !== want.char_out)
            report_mismatch("char_out", int'(seen.char_out), int'(want.char_out));
          if (seen.char_valid !== want.char_valid)
            report_mismatch("char_valid", int'(seen.char_valid), int'(want.char_valid));
          if (seen.activity !== want.activity)
            report_mismatch("activity", int'(seen.activity), int'(want.activity));
          if (seen.overflow !== want.overflow)
            report_mismatch("overflow", int'(seen.overflow), int'(want.overflow));
          if (seen.kill_request !== want.kill_request)
            report_mismatch("kill_request", int'(seen.kill_request),
                            int'(want.kill_request));
        end
      end
    end
  end

  // reply side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // command side: called at a falling edge, returns at the falling edge after
  // the beat was taken; valid stays high into the next beat unless it idles
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [sc2a_pkg::OPCODE_W-1:0] op,
                           input logic [sc2a_pkg::CODE_W-1:0] code,
                           input logic typed = 1'b0, input sc2a_pkg::res_t want = '0);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.scan_code <= code;
    beat_typed      <= typed;
    beat_want       <= want;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // scancodes a user might plausibly type: mostly keys, often modifiers
  function automatic logic [sc2a_pkg::CODE_W-1:0] typed_code();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 8'($urandom_range(0, 8'h39));
    // c and d get extra weight so ctrl combinations show up
    if (pick < 63) return ($urandom_range(0, 1) != 0) ? 8'h2E : 8'h20;
    if (pick < 88) begin
      case ($urandom_range(0, 6))
        0:       return sc2a_pkg::SC_LSHIFT;
        1:       return sc2a_pkg::SC_RSHIFT;
        2:       return sc2a_pkg::SC_LSHIFT_UP;
        3:       return sc2a_pkg::SC_RSHIFT_UP;
        4:       return sc2a_pkg::SC_CTRL;
        5:       return sc2a_pkg::SC_CTRL_UP;
        default: return sc2a_pkg::SC_CAPS;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // one pacing phase of random traffic, optionally opened by a ring overfill
  task automatic random_phase(input int budget, input bit with_fill);
    int sent;
    int len;
    int mode;
    int pick;
    sent = 0;
    if (with_fill) begin
      // letters q..p only, so ctrl cannot turn a push into a kill
      len = $urandom_range(RING_DEPTH + 2, RING_DEPTH + 12);
      repeat (len) send_beat(sc2a_pkg::OP_SCAN, 8'($urandom_range(8'h10, 8'h19)));
      sent = len;
    end
    while (sent < budget) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        // typing with interleaved pops and the odd status read or clear
        len = $urandom_range(8, 30);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 30)      send_beat(sc2a_pkg::OP_POP, 8'($urandom_range(0, 255)));
          else if (pick < 36) send_beat(sc2a_pkg::OP_ACT, 8'($urandom_range(0, 255)));
          else if (pick < 38) send_beat(sc2a_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
          else                send_beat(sc2a_pkg::OP_SCAN, typed_code());
        end
      end else if (mode < 8) begin
        // drain, usually running into empty pops
        len = $urandom_range(10, 60);
        repeat (len) send_beat(sc2a_pkg::OP_POP, 8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(4, 12);
        repeat (len) send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed opening
  // ---------------------------------------------------------------------------
  step_t directed_steps [0:24] = '{
    '{sc2a_pkg::OP_ACT,   8'h00, 1'b1, QUIET_REPLY},              // no key since reset
    '{sc2a_pkg::OP_POP,   8'hFF, 1'b1, QUIET_REPLY},              // empty ring
    '{sc2a_pkg::OP_CLEAR, 8'h5A, 1'b1, QUIET_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h00, 1'b1, QUIET_REPLY},              // unmapped zero still pushed
    '{sc2a_pkg::OP_SCAN,  8'h7F, 1'b1, QUIET_REPLY},              // highest make code, unmapped
    '{sc2a_pkg::OP_SCAN,  8'h80, 1'b1, QUIET_REPLY},              // plain break, ignored
    '{sc2a_pkg::OP_SCAN,  8'hFF, 1'b1, QUIET_REPLY},
    '{sc2a_pkg::OP_ACT,   8'hA5, 1'b1, ACTIVITY_REPLY},
    '{sc2a_pkg::OP_POP,   8'h00, 1'b1, NUL_POP_REPLY},
    '{sc2a_pkg::OP_POP,   8'h00, 1'b1, NUL_POP_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h1E, 1'b0, QUIET_REPLY},              // a
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_LSHIFT, 1'b0, QUIET_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h1E, 1'b0, QUIET_REPLY},              // shifted a
    '{sc2a_pkg::OP_SCAN,  8'h2B, 1'b0, QUIET_REPLY},              // backslash turns into bar
    '{sc2a_pkg::OP_SCAN,  8'h08, 1'b0, QUIET_REPLY},              // 7 turns into ampersand
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_RSHIFT_UP, 1'b0, QUIET_REPLY}, // either release drops shift
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_CAPS, 1'b0, QUIET_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h2B, 1'b0, QUIET_REPLY},              // caps leaves backslash alone
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_CTRL, 1'b0, QUIET_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h2E, 1'b0, QUIET_REPLY},              // ctrl + caps + c pushes C
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_CAPS, 1'b0, QUIET_REPLY},
    '{sc2a_pkg::OP_SCAN,  8'h2E, 1'b1, KILL_REPLY},               // ctrl + c
    '{sc2a_pkg::OP_SCAN,  8'h20, 1'b0, QUIET_REPLY},              // ctrl + d pushes end of file
    '{sc2a_pkg::OP_SCAN,  sc2a_pkg::SC_CTRL_UP, 1'b0, QUIET_REPLY},
    '{sc2a_pkg::OP_POP,   8'h3C, 1'b0, QUIET_REPLY}
  };

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = sc2a_pkg::OP_SCAN;
    in_ch.scan_code = '0;
    out_ch.ready    = 1'b0;
    beat_typed      = 1'b0;
    beat_want       = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    mismatch_count  = 0;
    shadow_wr       = 0;
    shadow_rd       = 0;
    shift_on        = 1'b0;
    caps_lock       = 1'b0;
    ctrl_on         = 1'b0;
    key_seen        = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // back to back, no stalls
    foreach (directed_steps[i]) begin
      send_beat(directed_steps[i].op, directed_steps[i].code,
                directed_steps[i].typed, directed_steps[i].want);
    end
    random_phase(PHASE_BEATS, 1'b0);

    // sparse sender
    src_idle_pct  = 83;
    snk_stall_pct = 0;
    random_phase(PHASE_BEATS, 1'b0);

    // slow receiver, ring pushed past capacity
    src_idle_pct  = 0;
    snk_stall_pct = 83;
    random_phase(PHASE_BEATS, 1'b1);

    // both sides pausing now and then
    src_idle_pct  = 24;
    snk_stall_pct = 24;
    random_phase(PHASE_BEATS, 1'b1);

    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    // anything arriving now is an extra reply and gets flagged
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sc2a_pkg.sv
rtl/sc2a_if.sv
rtl/sc2a_ctrl.sv
rtl/sc2a_datapath.sv
rtl/scancode_to_ascii_fifo_top.sv
test/tb_scancode_to_ascii_fifo_top.sv
